[hw/rtl/tgrs_pkg.sv]
package tgrs_pkg;

  localparam int MAX_ROWS_DEF = 64;
  localparam int KEY_W = 32;
  localparam int TAG_W = 16;
  localparam int TOL_W = 31;
  // 0.1 in Q15.16, rounded to nearest
  localparam logic [TOL_W-1:0] TOL_RESET = 31'd6554;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_MARK,
    ST_SORT,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_MARK,
    CELL_SWAP,
    CELL_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic             parity;
    logic [TOL_W-1:0] tol;
  } cell_ctl_t;

endpackage

[hw/rtl/tgrs_ifs.sv]
interface tgrs_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [tgrs_pkg::KEY_W-1:0] primary_key;
  logic signed [tgrs_pkg::KEY_W-1:0] secondary_key;
  logic        [tgrs_pkg::TAG_W-1:0] row_tag;
  logic                             end_of_set;
  modport source (output valid, primary_key, secondary_key, row_tag, end_of_set,
                  input ready);
  modport sink (input valid, primary_key, secondary_key, row_tag, end_of_set,
                output ready);
endinterface

interface tgrs_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [tgrs_pkg::KEY_W-1:0] sorted_primary;
  logic signed [tgrs_pkg::KEY_W-1:0] sorted_secondary;
  logic        [tgrs_pkg::TAG_W-1:0] sorted_tag;
  logic                             group_start;
  logic                             last_row;
  logic                             overflowed;
  modport source (output valid, sorted_primary, sorted_secondary, sorted_tag,
                  group_start, last_row, overflowed, input ready);
  modport sink (input valid, sorted_primary, sorted_secondary, sorted_tag,
                group_start, last_row, overflowed, output ready);
endinterface

interface tgrs_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [tgrs_pkg::TOL_W-1:0]       data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[hw/rtl/tgrs_cell.sv]
module tgrs_cell #(
  parameter int IW  = 6,
  parameter int IDX = 0
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tgrs_pkg::cell_ctl_t               ctl,
  // new row on load
  input  logic signed [tgrs_pkg::KEY_W-1:0] new_p,
  input  logic signed [tgrs_pkg::KEY_W-1:0] new_s,
  input  logic        [tgrs_pkg::TAG_W-1:0] new_tag,
  input  logic        [IW-1:0]              new_idx,
  // left neighbor
  input  logic                              l_valid,
  input  logic signed [tgrs_pkg::KEY_W-1:0] l_p,
  input  logic signed [tgrs_pkg::KEY_W-1:0] l_s,
  input  logic        [tgrs_pkg::TAG_W-1:0] l_tag,
  input  logic        [IW-1:0]              l_idx,
  input  logic                              l_ins,
  input  logic                              l_swap,
  // right neighbor
  input  logic                              r_valid,
  input  logic signed [tgrs_pkg::KEY_W-1:0] r_p,
  input  logic signed [tgrs_pkg::KEY_W-1:0] r_s,
  input  logic        [tgrs_pkg::TAG_W-1:0] r_tag,
  input  logic        [IW-1:0]              r_idx,
  input  logic                              r_start,
  // own contents
  output logic                              valid_r,
  output logic signed [tgrs_pkg::KEY_W-1:0] p_r,
  output logic signed [tgrs_pkg::KEY_W-1:0] s_r,
  output logic        [tgrs_pkg::TAG_W-1:0] tag_r,
  output logic        [IW-1:0]              idx_r,
  output logic                              start_r,
  output logic                              ins,
  output logic                              swap
);

  logic [tgrs_pkg::KEY_W:0] diff;
  logic                     after_r;

  // new row goes ahead of this cell's row
  assign ins = !valid_r || (p_r > new_p);

  // this row must follow the right one inside a group
  assign after_r = (s_r > r_s) || ((s_r == r_s) && (idx_r > r_idx));
  assign swap = (ctl.op == tgrs_pkg::CELL_SWAP) && (IDX % 2 == int'(ctl.parity))
                && valid_r && r_valid && !r_start && after_r;

  assign diff = {p_r[tgrs_pkg::KEY_W-1], p_r} - {l_p[tgrs_pkg::KEY_W-1], l_p};

  // hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      case (ctl.op)
        tgrs_pkg::CELL_LOAD: begin
          if (l_ins) valid_r <= l_valid;
          else if (ins) valid_r <= 1'b1;
        end
        tgrs_pkg::CELL_SHIFT: valid_r <= r_valid;
        default: ;
      endcase
    end
  end

  // move payload
  always_ff @(posedge clk) begin
    case (ctl.op)
      tgrs_pkg::CELL_LOAD: begin
        if (l_ins) begin
          p_r <= l_p; s_r <= l_s; tag_r <= l_tag; idx_r <= l_idx;
        end else if (ins) begin
          p_r <= new_p; s_r <= new_s; tag_r <= new_tag; idx_r <= new_idx;
        end
      end
      tgrs_pkg::CELL_MARK: begin
        start_r <= (IDX == 0) || (diff >= {2'b00, ctl.tol});
      end
      tgrs_pkg::CELL_SWAP: begin
        if (swap) begin
          p_r <= r_p; s_r <= r_s; tag_r <= r_tag; idx_r <= r_idx;
        end else if (l_swap) begin
          p_r <= l_p; s_r <= l_s; tag_r <= l_tag; idx_r <= l_idx;
        end
      end
      tgrs_pkg::CELL_SHIFT: begin
        p_r <= r_p; s_r <= r_s; tag_r <= r_tag; idx_r <= r_idx;
        start_r <= r_start;
      end
      default: ;
    endcase
  end

endmodule

[hw/rtl/two_key_grouped_row_sort.sv]
// channel  | dir | beat contents
// in_bus   | in  | primary_key, secondary_key, row_tag, end_of_set
// out_bus  | out | sorted_primary, sorted_secondary, sorted_tag, flags
// cfg_bus  | in  | group_tolerance (Q15.16, 31 bits)
// Rows load one per cycle into the insertion chain; after the end-marked row
// the mark state marks groups, MAX_ROWS odd-even exchange passes sort the groups,
// then one row leaves per cycle from the chain head while the receiver takes it.
// Input is refused from the end mark until the last row is taken; a stalled
// result holds the chain. Reset empties the chain; the tolerance returns to 6554.
module two_key_grouped_row_sort #(
  parameter int MAX_ROWS = tgrs_pkg::MAX_ROWS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  tgrs_in_if.sink       in_bus,
  tgrs_out_if.source    out_bus,
  tgrs_cfg_if.sink      cfg_bus
);

  localparam int IW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_ROWS + 1);
  localparam int KW = tgrs_pkg::KEY_W;
  localparam int TW = tgrs_pkg::TAG_W;

  tgrs_pkg::state_t  state_r, state_nxt;
  tgrs_pkg::cell_ctl_t ctl;
  logic [tgrs_pkg::TOL_W-1:0] tol_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] pass_r, pass_nxt;
  logic          ovf_r, ovf_nxt;
  logic          in_acc, out_acc, full;

  logic           c_valid [MAX_ROWS+1];
  logic signed [KW-1:0] c_p [MAX_ROWS+1];
  logic signed [KW-1:0] c_s [MAX_ROWS+1];
  logic [TW-1:0]  c_tag   [MAX_ROWS+1];
  logic [IW-1:0]  c_idx   [MAX_ROWS+1];
  logic           c_start [MAX_ROWS+1];
  logic           c_ins   [MAX_ROWS];
  logic           c_swap  [MAX_ROWS];

  assign full    = (count_r == CW'(MAX_ROWS));
  assign in_bus.ready = (state_r == tgrs_pkg::ST_LOAD);
  assign in_acc  = in_bus.valid && in_bus.ready;
  assign out_acc = out_bus.valid && out_bus.ready;
  assign cfg_bus.ready = 1'b1;

  // hold tolerance
  always_ff @(posedge clk) begin
    if (!rst_n) tol_r <= tgrs_pkg::TOL_RESET;
    else if (cfg_bus.valid && cfg_bus.ready) tol_r <= cfg_bus.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tgrs_pkg::ST_LOAD;
      count_r <= '0;
      pass_r  <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pass_r  <= pass_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // sequence load, mark, sort, emit
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    pass_nxt   = pass_r;
    ovf_nxt    = ovf_r;
    ctl.op     = tgrs_pkg::CELL_HOLD;
    ctl.parity = pass_r[0];
    ctl.tol    = tol_r;
    case (state_r)
      tgrs_pkg::ST_LOAD: begin
        if (in_acc) begin
          if (full) ovf_nxt = 1'b1;
          else begin
            ctl.op = tgrs_pkg::CELL_LOAD;
            count_nxt = count_r + 1'b1;
          end
          if (in_bus.end_of_set) state_nxt = tgrs_pkg::ST_MARK;
        end
      end
      tgrs_pkg::ST_MARK: begin
        ctl.op = tgrs_pkg::CELL_MARK;
        pass_nxt = '0;
        state_nxt = tgrs_pkg::ST_SORT;
      end
      tgrs_pkg::ST_SORT: begin
        ctl.op = tgrs_pkg::CELL_SWAP;
        pass_nxt = pass_r + 1'b1;
        if (pass_r == CW'(MAX_ROWS - 1)) state_nxt = tgrs_pkg::ST_EMIT;
      end
      tgrs_pkg::ST_EMIT: begin
        if (out_acc) begin
          ctl.op = tgrs_pkg::CELL_SHIFT;
          if (out_bus.last_row) begin
            state_nxt = tgrs_pkg::ST_LOAD;
            count_nxt = '0;
            ovf_nxt   = 1'b0;
          end
        end
      end
      default: state_nxt = tgrs_pkg::ST_LOAD;
    endcase
  end

  // empty slot past the chain end
  assign c_valid[MAX_ROWS] = 1'b0;
  assign c_p[MAX_ROWS]     = '0;
  assign c_s[MAX_ROWS]     = '0;
  assign c_tag[MAX_ROWS]   = '0;
  assign c_idx[MAX_ROWS]   = '0;
  assign c_start[MAX_ROWS] = 1'b1;

  for (genvar i = 0; i < MAX_ROWS; i++) begin : g_cell
    tgrs_cell #(.IW(IW), .IDX(i)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .new_p   (in_bus.primary_key),
      .new_s   (in_bus.secondary_key),
      .new_tag (in_bus.row_tag),
      .new_idx (count_r[IW-1:0]),
      .l_valid ((i == 0) ? 1'b0 : c_valid[(i == 0) ? 0 : i-1]),
      .l_p     (c_p[(i == 0) ? 0 : i-1]),
      .l_s     (c_s[(i == 0) ? 0 : i-1]),
      .l_tag   (c_tag[(i == 0) ? 0 : i-1]),
      .l_idx   (c_idx[(i == 0) ? 0 : i-1]),
      .l_ins   ((i == 0) ? 1'b0 : c_ins[(i == 0) ? 0 : i-1]),
      .l_swap  ((i == 0) ? 1'b0 : c_swap[(i == 0) ? 0 : i-1]),
      .r_valid (c_valid[i+1]),
      .r_p     (c_p[i+1]),
      .r_s     (c_s[i+1]),
      .r_tag   (c_tag[i+1]),
      .r_idx   (c_idx[i+1]),
      .r_start (c_start[i+1]),
      .valid_r (c_valid[i]),
      .p_r     (c_p[i]),
      .s_r     (c_s[i]),
      .tag_r   (c_tag[i]),
      .idx_r   (c_idx[i]),
      .start_r (c_start[i]),
      .ins     (c_ins[i]),
      .swap    (c_swap[i])
    );
  end

  // present chain head
  assign out_bus.valid            = (state_r == tgrs_pkg::ST_EMIT) && c_valid[0];
  assign out_bus.sorted_primary   = c_p[0];
  assign out_bus.sorted_secondary = c_s[0];
  assign out_bus.sorted_tag       = c_tag[0];
  assign out_bus.group_start      = c_start[0];
  assign out_bus.last_row         = !c_valid[1];
  assign out_bus.overflowed       = ovf_r;

endmodule

[hw/rtl/tgrs_checker.sv]
module tgrs_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last,
  input logic out_ovf
);

  // never load while a set drains
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("load and emit overlap");

  // burst continues without gaps and with a steady overflow flag
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |=> (out_valid && $stable(out_ovf)))
    else $error("burst broken");

  // last beat returns to loading
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |=> (!out_valid && in_ready))
    else $error("no return to load");

  // stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");

endmodule

bind two_key_grouped_row_sort tgrs_checker u_tgrs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_bus.valid),
  .in_ready  (in_bus.ready),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .out_last  (out_bus.last_row),
  .out_ovf   (out_bus.overflowed)
);

[verif/tb_tgrs_ifs.sv]
`timescale 1ns / 100ps
// Interfaces come from the RTL file tgrs_ifs.sv; this file holds the testbench's row record.
package tb_tgrs_types;
  typedef struct {
    logic signed [tgrs_pkg::KEY_W-1:0] pkey;
    logic signed [tgrs_pkg::KEY_W-1:0] skey;
    logic [tgrs_pkg::TAG_W-1:0]        tag;
    logic                              grp;
    logic                              last;
    logic                              ovf;
  } sorted_row_t;
endpackage

[verif/tb_two_key_grouped_row_sort.sv]
`timescale 1ns / 100ps
module tb_two_key_grouped_row_sort;

  localparam int ROWS = tgrs_pkg::MAX_ROWS_DEF;
  localparam int KW = tgrs_pkg::KEY_W;
  localparam int TW = tgrs_pkg::TAG_W;
  localparam int OW = tgrs_pkg::TOL_W;
  localparam int IDLE_LIMIT = 20000;

  // Collect rows of a set and sort them the way the block must.
  class row_sort_board;
    logic signed [KW-1:0] pk[$];
    logic signed [KW-1:0] sk[$];
    logic [TW-1:0] tg[$];
    bit dropped;
    logic [OW-1:0] tol;
    tb_tgrs_types::sorted_row_t expected_rows[$];
    int errors;

    function void note_row(logic signed [KW-1:0] p, logic signed [KW-1:0] s,
                           logic [TW-1:0] t, bit eos);
      int ord[$];
      bit st[$];
      int n, i, j, cur, s0, e;
      logic signed [KW:0] d;
      tb_tgrs_types::sorted_row_t r;
      if (pk.size() < ROWS) begin
        pk = {pk, p}; sk = {sk, s}; tg = {tg, t};
      end else begin
        dropped = 1;
      end
      if (!eos) return;
      n = pk.size();
      // stable insertion by primary key
      for (i = 0; i < n; i++) begin
        ord = {ord, i};
        j = i;
        while (j > 0 && pk[ord[j-1]] > pk[i]) begin
          ord[j] = ord[j-1]; j--;
        end
        ord[j] = i;
      end
      for (i = 0; i < n; i++) begin
        if (i == 0) st = {st, 1'b1};
        else begin
          d = {pk[ord[i]][KW-1], pk[ord[i]]} - {pk[ord[i-1]][KW-1], pk[ord[i-1]]};
          st = {st, !(d < {2'b00, tol})};
        end
      end
      // stable sort within each group by secondary key
      s0 = 0;
      while (s0 < n) begin
        e = s0 + 1;
        while (e < n && !st[e]) e++;
        for (i = s0 + 1; i < e; i++) begin
          cur = ord[i]; j = i;
          while (j > s0 && (sk[ord[j-1]] > sk[cur] ||
                 (sk[ord[j-1]] == sk[cur] && ord[j-1] > cur))) begin
            ord[j] = ord[j-1]; j--;
          end
          ord[j] = cur;
        end
        s0 = e;
      end
      for (i = 0; i < n; i++) begin
        r.pkey = pk[ord[i]]; r.skey = sk[ord[i]]; r.tag = tg[ord[i]];
        r.grp = st[i]; r.last = (i == n - 1); r.ovf = dropped;
        expected_rows = {expected_rows, r};
      end
      pk.delete(); sk.delete(); tg.delete(); dropped = 0;
    endfunction

    function void check_row(tb_tgrs_types::sorted_row_t a);
      tb_tgrs_types::sorted_row_t x;
      if (expected_rows.size() == 0) begin
        $error("unexpected row tag=%0h", a.tag); errors++; return;
      end
      x = expected_rows.pop_front();
      if (a.pkey !== x.pkey) begin
        $error("sorted_primary exp %0d got %0d", x.pkey, a.pkey); errors++;
      end
      if (a.skey !== x.skey) begin
        $error("sorted_secondary exp %0d got %0d", x.skey, a.skey); errors++;
      end
      if (a.tag !== x.tag) begin
        $error("sorted_tag exp %0h got %0h", x.tag, a.tag); errors++;
      end
      if (a.grp !== x.grp) begin
        $error("group_start exp %0b got %0b", x.grp, a.grp); errors++;
      end
      if (a.last !== x.last) begin
        $error("last_row exp %0b got %0b", x.last, a.last); errors++;
      end
      if (a.ovf !== x.ovf) begin
        $error("overflowed exp %0b got %0b", x.ovf, a.ovf); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  tgrs_in_if in_bus();
  tgrs_out_if out_bus();
  tgrs_cfg_if cfg_bus();

  two_key_grouped_row_sort u_dut (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus), .out_bus(out_bus), .cfg_bus(cfg_bus)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  row_sort_board board;
  int send_idle_pct, take_stall_pct;
  int idle_cycles = 0;

  initial begin
    in_bus.valid = 0; in_bus.primary_key = 0; in_bus.secondary_key = 0;
    in_bus.row_tag = 0; in_bus.end_of_set = 0;
    cfg_bus.valid = 0; cfg_bus.data = 0; out_bus.ready = 0;
    board = new();
    board.tol = tgrs_pkg::TOL_RESET;
  end

  // Receiver: random stalls, check each accepted beat.
  always @(posedge clk) begin
    tb_tgrs_types::sorted_row_t r;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      r.pkey = out_bus.sorted_primary; r.skey = out_bus.sorted_secondary;
      r.tag = out_bus.sorted_tag; r.grp = out_bus.group_start;
      r.last = out_bus.last_row; r.ovf = out_bus.overflowed;
      board.check_row(r);
    end
    out_bus.ready <= ($urandom_range(99) >= take_stall_pct);
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready) || !rst_n)
      idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("** two_key_grouped_row_sort: FAILED **");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // Drop valid only when the sender idles; back-to-back beats keep it high.
  task automatic send_row(logic signed [KW-1:0] p, logic signed [KW-1:0] s,
                          logic [TW-1:0] t, bit eos);
    if ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_bus.valid <= 1; in_bus.primary_key <= p; in_bus.secondary_key <= s;
    in_bus.row_tag <= t; in_bus.end_of_set <= eos;
    do @(posedge clk); while (!in_bus.ready);
    board.note_row(p, s, t, eos);
  endtask

  task automatic drain();
    in_bus.valid <= 0;
    while (board.expected_rows.size() != 0) @(posedge clk);
    repeat (ROWS + 10) @(posedge clk);
  endtask

  task automatic write_tol(logic [OW-1:0] v);
    cfg_bus.valid <= 1; cfg_bus.data <= v;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 0;
    board.tol = v;
  endtask

  // Keys mostly clustered so groups form, sometimes full-range.
  function automatic logic signed [KW-1:0] rand_key(int mode);
    case (mode)
      0: return $signed($urandom);
      1: return $signed($urandom_range(8)) <<< 14;
      default: return $signed($urandom_range(40)) - 20;
    endcase
  endfunction

  task automatic random_sets(int rows_goal);
    int sent, n, k, mode;
    sent = 0;
    while (sent < rows_goal) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(ROWS + 4, ROWS) : $urandom_range(12, 1);
      mode = $urandom_range(2);
      for (k = 0; k < n; k++)
        send_row(rand_key(mode), rand_key($urandom_range(2)), TW'($urandom), k == n - 1);
      sent += n;
    end
  endtask

  initial begin
    int k;
    send_idle_pct = 0; take_stall_pct = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: extremes, ties, single-row set, lone final group, tolerance edge.
    send_row(32'sh7FFFFFFF, 32'sh80000000, 16'hFFFF, 0);
    send_row(32'sh80000000, 32'sh7FFFFFFF, 16'h0000, 0);
    send_row(0, 5, 16'h0001, 0);
    send_row(6553, 5, 16'h0002, 0);
    send_row(6553 + 6554, -1, 16'h0003, 0);
    send_row(0, 5, 16'h0004, 1);
    send_row(100, 100, 16'hA5A5, 1);
    send_row(0, 0, 16'h5A5A, 0);
    send_row(1 << 20, 0, 16'h1234, 1);
    for (k = 0; k < ROWS + 2; k++)
      send_row(ROWS - k, k, TW'(k), k == ROWS + 1);
    drain();

    // Tolerance extremes and mid values across idling phases.
    write_tol(OW'(0));
    random_sets(30);
    drain();
    write_tol(31'h7FFFFFFF);
    send_idle_pct = 71;
    random_sets(40);
    drain();
    write_tol(OW'(1));
    send_idle_pct = 0; take_stall_pct = 71;
    random_sets(50);
    drain();
    write_tol(OW'(1 << 14));
    send_idle_pct = 38; take_stall_pct = 38;
    random_sets(50);
    drain();
    write_tol(OW'($urandom_range(31'h7FFFFFFF)));
    send_idle_pct = 0; take_stall_pct = 0;
    random_sets(50);
    drain();

    if (board.errors == 0 && board.expected_rows.size() == 0)
      $display("** two_key_grouped_row_sort: PASSED **");
    else
      $display("** two_key_grouped_row_sort: FAILED **");
    $finish;
  end
endmodule
